>>> rtl/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types and constants of the bloom filter insert/query block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

  localparam int MAX_BITS   = 1024;
  localparam int MAX_HASHES = 8;
  localparam int ADDR_W     = $clog2(MAX_BITS);
  localparam int HSEL_W     = $clog2(MAX_HASHES);

  localparam int KEY_W      = 64;
  localparam int PRIME_W    = 16;
  localparam int TSIZE_W    = 11;
  localparam int HCNT_W     = 4;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIV_CNT_W  = $clog2(KEY_W + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIME        = 3'd0,
    REG_TABLE_SIZE   = 3'd1,
    REG_HASH_COUNT   = 3'd2,
    REG_COEFF_A_LOW  = 3'd3,
    REG_COEFF_A_HIGH = 3'd4,
    REG_COEFF_B_LOW  = 3'd5,
    REG_COEFF_B_HIGH = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic was_query;
    logic found;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              clr;
    logic [ADDR_W-1:0] clr_addr;
    logic              load_item;
    logic              mul_lo;
    logic              mul_hi;
    logic              sum;
    logic              div_start;
    logic              div_sel;    // 0: reduce by prime, 1: reduce by table size
    logic              mem_access;
    logic              check;
    logic              load_out;
    logic [HSEL_W-1:0] hash_sel;
  } bfiq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              div_busy;
    logic              div_done;
    logic              prime_nz;
    logic [HCNT_W-1:0] hash_num;
  } bfiq_sts_t;

endpackage

>>> rtl/bfiq_div.sv
// ----------------------------------------------------------------------------
// bfiq_div
// Restoring remainder unit, one dividend bit per cycle. A short operation
// takes only the low 16 dividend bits.
// ----------------------------------------------------------------------------
module bfiq_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    short_i,
  input  logic [bfiq_pkg::KEY_W-1:0]   dividend_i,
  input  logic [bfiq_pkg::PRIME_W-1:0] divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [bfiq_pkg::PRIME_W-1:0] rem_o
);
  import bfiq_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [KEY_W-1:0]     dvd_q;
  logic [PRIME_W-1:0]   div_q, rem_q;
  logic [PRIME_W:0]     trial, diff;
  logic                 ge;

  assign trial = {rem_q, dvd_q[KEY_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= short_i ? DIV_CNT_W'(PRIME_W) : DIV_CNT_W'(KEY_W);
      end else if (busy_q) begin
        cnt_q  <= cnt_q - 1'b1;
        busy_q <= cnt_q != DIV_CNT_W'(1);
        done_q <= cnt_q == DIV_CNT_W'(1);
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      dvd_q <= short_i ? {dividend_i[PRIME_W-1:0], {(KEY_W-PRIME_W){1'b0}}} : dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
      dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/bfiq_datapath.sv
// ----------------------------------------------------------------------------
// bfiq_datapath
// Configuration registers, hash arithmetic, shared remainder unit and the
// filter bit store.
// ----------------------------------------------------------------------------
module bfiq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  bfiq_pkg::in_item_t            in_data_i,
  input  bfiq_pkg::bfiq_cmd_t           cmd_i,
  output bfiq_pkg::bfiq_sts_t           sts_o,
  output bfiq_pkg::out_item_t           out_data_o
);
  import bfiq_pkg::*;

  logic [PRIME_W-1:0]    prime_q;
  logic [TSIZE_W-1:0]    tsize_q;
  logic [HCNT_W-1:0]     hcnt_q;
  logic [CFG_DATA_W-1:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q;

  logic                  item_cmd_q;
  logic [KEY_W-1:0]      key_q;
  logic                  found_q;
  logic [47:0]           p_lo_q;
  logic [31:0]           p_hi_q;
  logic [KEY_W-1:0]      h_q;
  out_item_t             out_q;

  logic                  mem_q [MAX_BITS];
  logic                  rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= PRIME_W'(1019);
      tsize_q <= TSIZE_W'(50);
      hcnt_q  <= HCNT_W'(MAX_HASHES);
      a_lo_q  <= '0;
      a_hi_q  <= '0;
      b_lo_q  <= '0;
      b_hi_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PRIME:        prime_q <= cfg_data_i[PRIME_W-1:0];
        REG_TABLE_SIZE:   tsize_q <= cfg_data_i[TSIZE_W-1:0];
        REG_HASH_COUNT:   hcnt_q  <= cfg_data_i[HCNT_W-1:0];
        REG_COEFF_A_LOW:  a_lo_q  <= cfg_data_i;
        REG_COEFF_A_HIGH: a_hi_q  <= cfg_data_i;
        REG_COEFF_B_LOW:  b_lo_q  <= cfg_data_i;
        REG_COEFF_B_HIGH: b_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective limits
  logic [TSIZE_W-1:0] m_eff;
  logic [HCNT_W-1:0]  r_eff;
  logic               prime_nz;

  assign m_eff = (tsize_q == '0) ? TSIZE_W'(1) :
                 (tsize_q > TSIZE_W'(MAX_BITS)) ? TSIZE_W'(MAX_BITS) : tsize_q;
  assign r_eff = (hcnt_q > HCNT_W'(MAX_HASHES)) ? HCNT_W'(MAX_HASHES) : hcnt_q;
  assign prime_nz = prime_q != '0;

  // coefficient pick for the current hash
  logic [CFG_DATA_W-1:0] a_word, b_word;
  logic [COEF_W-1:0]     a_sel, b_sel;
  logic [5:0]            fld_lsb;

  assign a_word  = cmd_i.hash_sel[HSEL_W-1] ? a_hi_q : a_lo_q;
  assign b_word  = cmd_i.hash_sel[HSEL_W-1] ? b_hi_q : b_lo_q;
  assign fld_lsb = {cmd_i.hash_sel[1:0], 4'd0};
  assign a_sel   = a_word[fld_lsb +: COEF_W];
  assign b_sel   = b_word[fld_lsb +: COEF_W];

  // 16x64 product mod 2^64 in two 16x32 halves
  logic [47:0] p_lo, p_hi;
  assign p_lo = {32'd0, a_sel} * {16'd0, key_q[31:0]};
  assign p_hi = {32'd0, a_sel} * {16'd0, key_q[63:32]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_cmd_q <= in_data_i.command;
      key_q      <= in_data_i.key;
    end
    if (cmd_i.mul_lo) p_lo_q <= p_lo;
    if (cmd_i.mul_hi) p_hi_q <= p_hi[31:0];
    if (cmd_i.sum)    h_q    <= {16'd0, p_lo_q} + {p_hi_q, 32'd0} + {48'd0, b_sel};
    if (cmd_i.load_item) begin
      found_q <= 1'b1;
    end else if (cmd_i.check && item_cmd_q == CMD_QUERY) begin
      found_q <= found_q & rd_q;
    end
    if (cmd_i.load_out) begin
      out_q.was_query <= item_cmd_q == CMD_QUERY;
      out_q.found     <= (item_cmd_q == CMD_QUERY) & found_q;
    end
  end

  // shared remainder unit: first by prime (skipped when the prime is zero), then by table size
  logic [KEY_W-1:0]   div_dvd;
  logic [PRIME_W-1:0] div_dsr, div_rem;
  logic               div_short, div_busy, div_done;

  always_comb begin
    if (!cmd_i.div_sel) begin
      div_dvd   = h_q;
      div_dsr   = prime_q;
      div_short = 1'b0;
    end else begin
      div_dvd   = prime_nz ? {{(KEY_W-PRIME_W){1'b0}}, div_rem} : h_q;
      div_dsr   = PRIME_W'(m_eff);
      div_short = prime_nz;
    end
  end

  bfiq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .short_i    (div_short),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // filter bit store, remainder is below the table size
  logic [ADDR_W-1:0] pos, wr_addr;
  logic              wr_en, wr_data;

  assign pos     = div_rem[ADDR_W-1:0];
  assign wr_en   = cmd_i.clr | (cmd_i.mem_access & (item_cmd_q == CMD_INSERT));
  assign wr_addr = cmd_i.clr ? cmd_i.clr_addr : pos;
  assign wr_data = !cmd_i.clr;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[pos];
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.prime_nz = prime_nz;
  assign sts_o.hash_num = r_eff;
  assign out_data_o     = out_q;

endmodule

>>> rtl/bfiq_ctrl.sv
// ----------------------------------------------------------------------------
// bfiq_ctrl
// Sequencer: clearing pass, per-hash steps and the output beat.
// ----------------------------------------------------------------------------
module bfiq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  bfiq_pkg::bfiq_sts_t sts_i,
  output bfiq_pkg::bfiq_cmd_t cmd_o
);
  import bfiq_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_LAUNCH,
    ST_DIV_P,
    ST_DIV_M,
    ST_ACCESS,
    ST_CHECK,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] clr_q;
  logic [HCNT_W-1:0] idx_q;
  logic              out_valid_q;
  logic              out_free;
  logic [HCNT_W-1:0] idx_nxt;

  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_nxt  = idx_q + 1'b1;

  always_comb begin
    cmd_o            = '0;
    cmd_o.clr_addr   = clr_q;
    cmd_o.hash_sel   = idx_q[HSEL_W-1:0];
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr       = 1'b1;
      ST_IDLE:   cmd_o.load_item = in_valid_i;
      ST_MUL_LO: cmd_o.mul_lo    = 1'b1;
      ST_MUL_HI: cmd_o.mul_hi    = 1'b1;
      ST_SUM:    cmd_o.sum       = 1'b1;
      ST_LAUNCH: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = !sts_i.prime_nz;
      end
      ST_DIV_P: begin
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel   = 1'b1;
      end
      ST_DIV_M:  ;
      ST_ACCESS: cmd_o.mem_access = 1'b1;
      ST_CHECK:  cmd_o.check      = 1'b1;
      ST_FINISH: cmd_o.load_out   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(MAX_BITS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            state_q <= (sts_i.hash_num == '0) ? ST_FINISH : ST_MUL_LO;
          end
        end
        ST_MUL_LO: state_q <= ST_MUL_HI;
        ST_MUL_HI: state_q <= ST_SUM;
        ST_SUM:    state_q <= ST_LAUNCH;
        ST_LAUNCH: state_q <= sts_i.prime_nz ? ST_DIV_P : ST_DIV_M;
        ST_DIV_P:  if (sts_i.div_done) state_q <= ST_DIV_M;
        ST_DIV_M:  if (sts_i.div_done) state_q <= ST_ACCESS;
        ST_ACCESS: state_q <= ST_CHECK;
        ST_CHECK: begin
          idx_q   <= idx_nxt;
          state_q <= (idx_nxt < sts_i.hash_num) ? ST_MUL_LO : ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter over a 1024-bit store with up to eight universal hashes.
// ----------------------------------------------------------------------------
// Input beats carry a command (insert or query) and a 64-bit key; each input
// beat gives exactly one output beat (was_query, found). Both channels use
// valid/stall; a beat moves when valid is high and stall is low.
// For every hash in use the block forms a*key+b mod 2^64 with two 16x32
// multiplies, then reduces it on one shared bit-serial remainder unit: first
// by the prime, then by the table size on the low 16 bits of that remainder;
// when the prime is zero only the table-size stage runs, over all 64 bits.
// One item is in work at a time; in_stall_o is low only between items.
// The result sits in an output register, so the next item is taken and
// worked on while the receiver stalls; it then waits at its end until the
// register is free.
// After reset the store is swept to zero, one bit a cycle, over all 1024 bits,
// with in_stall_o high. Configuration writes are taken at any time, also
// during the sweep, and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bfiq_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bfiq_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bfiq_pkg::*;

  bfiq_cmd_t cmd;
  bfiq_sts_t sts;

  bfiq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfiq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in work");

  // the remainder unit is never restarted mid-operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("remainder unit started while busy");

  // the clearing sweep never overlaps a filter access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> (!cmd.mem_access && in_stall_o))
    else $error("filter access during clearing sweep");

  // an insert never reports found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.was_query || !out_data_o.found))
    else $error("insert beat reports found");

endmodule

>>> tb/bloom_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_result_checker
// Watches the input, output and register ports of the bloom filter, keeps its
// own copy of the settings and the bit store, works out the answer of every
// accepted input beat and compares it with the output beats in order.
// ----------------------------------------------------------------------------
module bloom_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  bfiq_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  bfiq_pkg::out_item_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_o
);
  import bfiq_pkg::*;

  localparam logic [PRIME_W-1:0] PRIME_RESET = 16'd1019;
  localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd50;
  localparam logic [HCNT_W-1:0]  HCNT_RESET  = 4'd8;

  logic [PRIME_W-1:0]    cur_prime;
  logic [TSIZE_W-1:0]    cur_tsize;
  logic [HCNT_W-1:0]     cur_hcnt;
  logic [KEY_W-1:0]      coef_a_lo, coef_a_hi, coef_b_lo, coef_b_hi;
  logic [MAX_BITS-1:0]   filter_bits;
  out_item_t             expected_results[$];
  out_item_t             oldest;
  int unsigned           mismatches;

  // ((a*key + b) mod 2^64) mod prime mod m, the prime stage skipped at zero
  function automatic logic [ADDR_W-1:0] bit_index(logic [KEY_W-1:0] hashed_key, int h,
                                                  logic [TSIZE_W-1:0] m);
    logic [KEY_W-1:0]  a_word, b_word, sum;
    logic [COEF_W-1:0] a, b;
    int                lane;
    a_word = (h < 4) ? coef_a_lo : coef_a_hi;
    b_word = (h < 4) ? coef_b_lo : coef_b_hi;
    lane   = (h % 4) * COEF_W;
    a      = a_word[lane +: COEF_W];
    b      = b_word[lane +: COEF_W];
    sum    = KEY_W'(a) * hashed_key + KEY_W'(b);
    if (cur_prime != '0) sum = sum % KEY_W'(cur_prime);
    sum = sum % KEY_W'(m);
    return sum[ADDR_W-1:0];
  endfunction

  // updates the store for an insert and gives the answer of the beat
  function automatic out_item_t filter_step(in_item_t item);
    logic [TSIZE_W-1:0] m;
    int unsigned        r;
    logic               hit;
    logic [ADDR_W-1:0]  pos;
    out_item_t          res;
    if (cur_tsize == '0) m = TSIZE_W'(1);
    else if (cur_tsize > MAX_BITS) m = TSIZE_W'(MAX_BITS);
    else m = cur_tsize;
    r   = (cur_hcnt > MAX_HASHES) ? MAX_HASHES : cur_hcnt;
    hit = 1'b1;
    for (int h = 0; h < r; h++) begin
      pos = bit_index(item.key, h, m);
      if (item.command == CMD_QUERY) hit &= filter_bits[pos];
      else filter_bits[pos] = 1'b1;
    end
    res.was_query = (item.command == CMD_QUERY);
    res.found     = res.was_query & hit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_prime   = PRIME_RESET;
      cur_tsize   = TSIZE_RESET;
      cur_hcnt    = HCNT_RESET;
      coef_a_lo   = '0;
      coef_a_hi   = '0;
      coef_b_lo   = '0;
      coef_b_hi   = '0;
      filter_bits = '0;
      mismatches  = 0;
      expected_results.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PRIME:        cur_prime = cfg_data_i[PRIME_W-1:0];
          REG_TABLE_SIZE:   cur_tsize = cfg_data_i[TSIZE_W-1:0];
          REG_HASH_COUNT:   cur_hcnt  = cfg_data_i[HCNT_W-1:0];
          REG_COEFF_A_LOW:  coef_a_lo = cfg_data_i;
          REG_COEFF_A_HIGH: coef_a_hi = cfg_data_i;
          REG_COEFF_B_LOW:  coef_b_lo = cfg_data_i;
          REG_COEFF_B_HIGH: coef_b_hi = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(filter_step(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected, got was_query %0b found %0b",
                   $time, out_data_i.was_query, out_data_i.found);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_data_i.was_query !== oldest.was_query) begin
            $display("%0t: was_query expected %0b got %0b",
                     $time, oldest.was_query, out_data_i.was_query);
            mismatches++;
          end
          if (out_data_i.found !== oldest.found) begin
            $display("%0t: found expected %0b got %0b", $time, oldest.found, out_data_i.found);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_o        <= expected_results.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives inserts and queries into the bloom filter under many register
// settings, with random gaps on the input and random stalls on the output;
// the checker beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module testbench;
  import bfiq_pkg::*;

  localparam int GAP_MAX      = 13;
  localparam int RANDOM_ITEMS = 1000;
  localparam int IDLE_LIMIT   = 8000;
  localparam int TAIL_CYCLES  = 64;
  // index past the last register, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [KEY_W-1:0]     ALL_ONES = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned mismatches, pending;
  int unsigned idle_cycles = 0;
  int unsigned hold_cnt    = 0;
  int unsigned stall_draw;
  int unsigned items_sent  = 0;
  int unsigned queries     = 0;
  int unsigned settings    = 0;
  int unsigned random_sent = 0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;
  logic [KEY_W-1:0] phase_keys[$];

  bloom_filter_insert_query uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
    .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  bloom_result_checker check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatches), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: a fresh stall length is drawn after every accepted beat, unless rx_quiet is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt    <= 0;
      out_stall_i <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      if (rx_quiet) begin
        hold_cnt    <= 0;
        out_stall_i <= 1'b0;
      end else begin
        stall_draw = $urandom_range(0, GAP_MAX);
        hold_cnt    <= stall_draw;
        out_stall_i <= (stall_draw != 0);
      end
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      hold_cnt    <= 0;
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] hashed_key);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{command: cmd, key: hashed_key};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (cmd == CMD_QUERY) queries++;
    else phase_keys.push_back(hashed_key);
  endtask

  // wait until every answer is back, the block is then idle
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  // with every_reg clear each register is written with a chance of three in four
  task automatic apply_settings(input bit every_reg, input logic [63:0] prime,
                                input logic [63:0] tsize, input logic [63:0] hcnt,
                                input logic [63:0] a_lo, input logic [63:0] a_hi,
                                input logic [63:0] b_lo, input logic [63:0] b_hi);
    if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_PRIME, prime);
    if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_TABLE_SIZE, tsize);
    if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_HASH_COUNT, hcnt);
    if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_COEFF_A_LOW, a_lo);
    if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_COEFF_A_HIGH, a_hi);
    if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_COEFF_B_LOW, b_lo);
    if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_COEFF_B_HIGH, b_hi);
    write_reg(REG_NONE, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    settings++;
    phase_keys.delete();
  endtask

  // junk above the register width now and then, it must be dropped
  function automatic logic [63:0] with_noise(logic [63:0] value, int w);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) return value;
    return (junk << w) | value;
  endfunction

  function automatic logic [63:0] random_coeffs();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_settings();
    logic [63:0] prime, tsize, hcnt;
    case ($urandom_range(0, 7))
      0:       prime = 64'd0;
      1:       prime = 64'd1;
      2:       prime = 64'd65535;
      3:       prime = 64'($urandom_range(2, 50));
      default: prime = 64'($urandom_range(2, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       tsize = 64'd0;
      1:       tsize = 64'($urandom_range(MAX_BITS + 1, 2047));
      2:       tsize = 64'(MAX_BITS);
      3, 4:    tsize = 64'($urandom_range(1, 16));
      default: tsize = 64'($urandom_range(17, MAX_BITS - 1));
    endcase
    case ($urandom_range(0, 15))
      0:       hcnt = 64'd0;
      1:       hcnt = 64'($urandom_range(MAX_HASHES + 1, 15));
      default: hcnt = 64'($urandom_range(1, MAX_HASHES));
    endcase
    apply_settings(settings == 6, with_noise(prime, PRIME_W), with_noise(tsize, TSIZE_W),
                   with_noise(hcnt, HCNT_W), random_coeffs(), random_coeffs(),
                   random_coeffs(), random_coeffs());
  endtask

  initial begin
    logic             cmd;
    logic [KEY_W-1:0] hashed_key;
    int unsigned      phase_len;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero coefficients put every hash on bit 0
    send_beat(CMD_QUERY, '0);
    send_beat(CMD_INSERT, ALL_ONES);
    send_beat(CMD_QUERY, '0);

    // prime zero skips the prime stage, full table
    settle();
    apply_settings(1'b1, 64'd0, 64'(MAX_BITS), 64'(MAX_HASHES), ALL_ONES,
                   {$urandom, $urandom}, ALL_ONES, '0);
    send_beat(CMD_QUERY, 64'h8000_0000_0000_0000);
    send_beat(CMD_INSERT, ALL_ONES);
    send_beat(CMD_QUERY, ALL_ONES);
    send_beat(CMD_INSERT, '0);
    send_beat(CMD_QUERY, '0);
    send_beat(CMD_QUERY, 64'h5555_5555_5555_5555);

    // no hashes at all: queries always hit, inserts touch nothing
    settle();
    apply_settings(1'b1, 64'd1, 64'd0, 64'd0, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
    send_beat(CMD_QUERY, {$urandom, $urandom});
    send_beat(CMD_INSERT, {$urandom, $urandom});

    // prime one with table size zero, everything lands on bit 0
    settle();
    apply_settings(1'b1, 64'd1, 64'd0, 64'(MAX_HASHES), ALL_ONES, ALL_ONES, ALL_ONES,
                   ALL_ONES);
    send_beat(CMD_QUERY, {$urandom, $urandom});
    send_beat(CMD_INSERT, ALL_ONES);

    // all-ones words: largest prime, oversized table and hash count saturate
    settle();
    apply_settings(1'b1, ALL_ONES, ALL_ONES, ALL_ONES, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    hashed_key = {$urandom, $urandom};
    send_beat(CMD_INSERT, hashed_key);
    send_beat(CMD_QUERY, hashed_key);
    send_beat(CMD_QUERY, ~hashed_key);
    send_beat(CMD_INSERT, '0);
    send_beat(CMD_QUERY, ALL_ONES);

    // smallest prime, one bit, one hash
    settle();
    apply_settings(1'b1, 64'd2, 64'd1, 64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
    send_beat(CMD_QUERY, {$urandom, $urandom});
    send_beat(CMD_INSERT, {$urandom, $urandom});
    send_beat(CMD_QUERY, {$urandom, $urandom});

    while (random_sent < RANDOM_ITEMS) begin
      settle();
      random_settings();
      tx_quiet  = ($urandom_range(0, 3) == 0);
      rx_quiet  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 100);
      repeat (phase_len) begin
        cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_INSERT;
        // queries often look up keys inserted under the same settings
        if (phase_keys.size() != 0 &&
            ((cmd == CMD_QUERY && $urandom_range(0, 1)) ||
             (cmd == CMD_INSERT && $urandom_range(0, 7) == 0)))
          hashed_key = phase_keys[$urandom_range(0, phase_keys.size() - 1)];
        else
          hashed_key = {$urandom, $urandom};
        send_beat(cmd, hashed_key);
        random_sent++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d items (%0d queries) under %0d register settings",
             items_sent, queries, settings);
    $display("settings took in zero and unit prime, zero and oversized table, no hashes");
    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
